[rtl/ugsl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugsl_pkg
// Shared constants and types for the glyph sprite layout block.
// ----------------------------------------------------------------------------
package ugsl_pkg;

    localparam int GLYPH_ENTRIES = 128;
    localparam int SLOT_W        = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int SCAN_W        = SLOT_W + 1;
    localparam int DIV_CNT_W     = $clog2(SLOT_W + 1);
    localparam int MUL_A_W       = (SLOT_W > 8) ? SLOT_W : 8;
    localparam int MUL_P_W       = MUL_A_W + 8;
    localparam int ENTRY_W       = 35;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COLUMNS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPABILITY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INDEX     = 3'd7;

    localparam logic [1:0] MODE_SOLID = 2'd0;
    localparam logic [1:0] MODE_RAMP  = 2'd1;
    localparam logic [1:0] MODE_ALPHA = 2'd2;

    localparam logic [7:0] UTF8_CONT_BIT  = 8'h80;
    localparam logic [7:0] UTF8_MASK2     = 8'hE0;
    localparam logic [7:0] UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0] UTF8_MASK3     = 8'hF0;
    localparam logic [7:0] UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0] UTF8_MASK4     = 8'hF8;
    localparam logic [7:0] UTF8_LEAD4     = 8'hF0;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_ADV   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_MUL_U = 8'b0001_0000,
        S_MUL_V = 8'b0010_0000,
        S_MUL_H = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

[rtl/ugsl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugsl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ugsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]                             i_wr_data,
    input  wire                                          i_rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/utf8_glyph_sprite_layout.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_glyph_sprite_layout
// Lays out UTF-8 text as glyph sprites from a loadable glyph table.
// ----------------------------------------------------------------------------
// Load and start words, and text bytes that do not complete a character, are
// taken without leaving the idle state. A byte that completes a character
// starts a linear search of the glyph RAM, one entry per cycle through its
// registered read port, stopping at the first match or after the last entry.
// A hit with a nonzero scale goes on to a restoring divide of the slot by the
// column count and three passes through the shared 8-bit multiplier. The
// block is not ready while a character is processed; a finished sprite sits in
// the output register and does not hold up the next input word, but a new
// sprite that finds the output register still full waits in place until the
// previous one is taken. The glyph table needs no clearing pass after reset:
// per-entry valid bits mark unused entries.
module utf8_glyph_sprite_layout (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [ugsl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [ugsl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [1:0]                       i_cmd,
    input  wire  [6:0]                       i_entry_slot,
    input  wire  [31:0]                      i_entry_code,
    input  wire  [2:0]                       i_entry_length,
    input  wire  signed [15:0]               i_start_x,
    input  wire  signed [15:0]               i_start_y,
    input  wire  [7:0]                       i_text_byte,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [15:0]               o_sprite_x,
    output logic signed [15:0]               o_sprite_y,
    output logic [11:0]                      o_sprite_width,
    output logic [11:0]                      o_sprite_height,
    output logic [14:0]                      o_source_u,
    output logic [14:0]                      o_source_v,
    output logic [1:0]                       o_draw_mode,
    output logic [15:0]                      o_tint
);

    import ugsl_pkg::*;

    // configuration
    logic [7:0]  r_cell_width;
    logic [7:0]  r_cell_height;
    logic [7:0]  r_atlas_columns;
    logic [3:0]  r_scale;
    logic [1:0]  r_requested_mode;
    logic [1:0]  r_capability;
    logic [15:0] r_ink_color;
    logic [7:0]  r_ramp_index;

    // control
    t_state                   r_state;
    logic [GLYPH_ENTRIES-1:0] r_glyph_vld;
    logic [15:0]              r_pen_x;
    logic [15:0]              r_pen_y;
    logic [31:0]              r_accum;
    logic [2:0]               r_needed;
    logic [2:0]               r_seen;
    logic                     r_stopped;
    logic [31:0]              r_code;
    logic [2:0]               r_len;
    logic [SCAN_W-1:0]        r_scan_idx;
    logic                     r_rd_pend;
    logic                     r_rd_vld;
    logic [SLOT_W-1:0]        r_rd_slot;
    logic                     r_hit;
    logic [SLOT_W-1:0]        r_slot;
    logic [7:0]               r_rem;
    logic [SLOT_W-1:0]        r_quo;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic                     r_out_valid;

    // result staging and output word
    logic [15:0] r_res_x;
    logic [11:0] r_res_w;
    logic [11:0] r_res_h;
    logic [14:0] r_res_u;
    logic [14:0] r_res_v;
    logic [15:0] r_sprite_x;
    logic [15:0] r_sprite_y;
    logic [11:0] r_sprite_width;
    logic [11:0] r_sprite_height;
    logic [14:0] r_source_u;
    logic [14:0] r_source_v;
    logic [1:0]  r_draw_mode;
    logic [15:0] r_tint;

    logic                 in_acc;
    logic                 load_ok;
    logic [SLOT_W-1:0]    wr_addr;
    logic                 rd_en;
    logic [ENTRY_W-1:0]   rd_data;
    logic [31:0]          len_mask;
    logic                 match;
    logic                 last_slot;
    logic [2:0]           lead_len;
    logic [31:0]          n_accum;
    logic [2:0]           n_seen;
    logic [7:0]           cols;
    logic [8:0]           div_trial;
    logic                 div_ge;
    logic [MUL_A_W-1:0]   mul_a;
    logic [7:0]           mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [1:0]           eff_mode;
    logic [15:0]          eff_color;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign load_ok = (32'(i_entry_slot) < 32'(GLYPH_ENTRIES));
    assign wr_addr = SLOT_W'(i_entry_slot);
    assign rd_en   = (r_state == S_SCAN) && (r_scan_idx < SCAN_W'(GLYPH_ENTRIES));

    ugsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_ENTRIES)
    ) u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && (i_cmd == CMD_LOAD) && load_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_entry_length, i_entry_code}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan_idx[SLOT_W-1:0]),
        .o_rd_data (rd_data)
    );

    // match against the entry read last cycle
    always_comb begin
        case (r_len)
            3'd1:    len_mask = 32'h0000_00FF;
            3'd2:    len_mask = 32'h0000_FFFF;
            3'd3:    len_mask = 32'h00FF_FFFF;
            3'd4:    len_mask = 32'hFFFF_FFFF;
            default: len_mask = 32'h0000_0000;
        endcase
    end

    assign match     = r_rd_pend && r_rd_vld && (rd_data[34:32] == r_len)
                       && (((rd_data[31:0] ^ r_code) & len_mask) == 32'd0);
    assign last_slot = (r_rd_slot == SLOT_W'(GLYPH_ENTRIES - 1));

    // utf-8 lead byte decode
    always_comb begin
        if ((i_text_byte & UTF8_CONT_BIT) == 8'd0) begin
            lead_len = 3'd1;
        end else if ((i_text_byte & UTF8_MASK2) == UTF8_LEAD2) begin
            lead_len = 3'd2;
        end else if ((i_text_byte & UTF8_MASK3) == UTF8_LEAD3) begin
            lead_len = 3'd3;
        end else if ((i_text_byte & UTF8_MASK4) == UTF8_LEAD4) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    assign n_accum = r_accum | (32'(i_text_byte) << {r_seen[1:0], 3'b000});
    assign n_seen  = r_seen + 3'd1;

    // restoring divide step
    assign cols      = (r_atlas_columns == 8'd0) ? 8'd1 : r_atlas_columns;
    assign div_trial = {r_rem, r_quo[SLOT_W-1]};
    assign div_ge    = (div_trial >= {1'b0, cols});

    // shared multiplier
    always_comb begin
        case (r_state)
            S_MUL_U: begin
                mul_a = MUL_A_W'(r_rem);
                mul_b = r_cell_width;
            end
            S_MUL_V: begin
                mul_a = MUL_A_W'(r_quo);
                mul_b = r_cell_height;
            end
            S_MUL_H: begin
                mul_a = MUL_A_W'(r_scale);
                mul_b = r_cell_height;
            end
            default: begin
                mul_a = MUL_A_W'(r_scale);
                mul_b = r_cell_width;
            end
        endcase
    end

    assign mul_p = {8'd0, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    always_comb begin
        if ((r_requested_mode == MODE_RAMP) && r_capability[0]) begin
            eff_mode  = MODE_RAMP;
            eff_color = {8'd0, r_ramp_index};
        end else if ((r_requested_mode == MODE_ALPHA) && r_capability[1]) begin
            eff_mode  = MODE_ALPHA;
            eff_color = r_ink_color;
        end else begin
            eff_mode  = MODE_SOLID;
            eff_color = r_ink_color;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width     <= 8'd8;
            r_cell_height    <= 8'd8;
            r_atlas_columns  <= 8'd16;
            r_scale          <= 4'd1;
            r_requested_mode <= MODE_SOLID;
            r_capability     <= 2'd0;
            r_ink_color      <= 16'hFFFF;
            r_ramp_index     <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_CELL_WIDTH:     r_cell_width     <= i_cfg_data[7:0];
                REG_CELL_HEIGHT:    r_cell_height    <= i_cfg_data[7:0];
                REG_ATLAS_COLUMNS:  r_atlas_columns  <= i_cfg_data[7:0];
                REG_SCALE:          r_scale          <= i_cfg_data[3:0];
                REG_REQUESTED_MODE: r_requested_mode <= i_cfg_data[1:0];
                REG_CAPABILITY:     r_capability     <= i_cfg_data[1:0];
                REG_INK_COLOR:      r_ink_color      <= i_cfg_data;
                REG_RAMP_INDEX:     r_ramp_index     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_glyph_vld <= '0;
            r_pen_x     <= 16'd0;
            r_pen_y     <= 16'd0;
            r_accum     <= 32'd0;
            r_needed    <= 3'd0;
            r_seen      <= 3'd0;
            r_stopped   <= 1'b1;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_cmd)
                            CMD_LOAD: begin
                                if (load_ok) begin
                                    r_glyph_vld[wr_addr] <= 1'b1;
                                end
                            end
                            CMD_START: begin
                                r_pen_x   <= i_start_x;
                                r_pen_y   <= i_start_y;
                                r_accum   <= 32'd0;
                                r_needed  <= 3'd0;
                                r_seen    <= 3'd0;
                                r_stopped <= 1'b0;
                            end
                            CMD_TEXT: begin
                                if (!r_stopped) begin
                                    if ((i_text_byte == 8'd0)
                                        || ((r_needed == 3'd0) && (lead_len == 3'd0))) begin
                                        r_stopped <= 1'b1;
                                        r_accum   <= 32'd0;
                                        r_needed  <= 3'd0;
                                        r_seen    <= 3'd0;
                                    end else if (r_needed == 3'd0) begin
                                        if (lead_len == 3'd1) begin
                                            r_code     <= {24'd0, i_text_byte};
                                            r_len      <= 3'd1;
                                            r_scan_idx <= '0;
                                            r_rd_pend  <= 1'b0;
                                            r_state    <= S_SCAN;
                                        end else begin
                                            r_accum  <= {24'd0, i_text_byte};
                                            r_needed <= lead_len;
                                            r_seen   <= 3'd1;
                                        end
                                    end else if (n_seen >= r_needed) begin
                                        r_code     <= n_accum;
                                        r_len      <= r_needed;
                                        r_accum    <= 32'd0;
                                        r_needed   <= 3'd0;
                                        r_seen     <= 3'd0;
                                        r_scan_idx <= '0;
                                        r_rd_pend  <= 1'b0;
                                        r_state    <= S_SCAN;
                                    end else begin
                                        r_accum <= n_accum;
                                        r_seen  <= n_seen;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_vld  <= r_glyph_vld[r_scan_idx[SLOT_W-1:0]];
                    r_rd_slot <= r_scan_idx[SLOT_W-1:0];
                    if (rd_en) begin
                        r_scan_idx <= r_scan_idx + SCAN_W'(1);
                    end
                    if (match) begin
                        r_hit     <= 1'b1;
                        r_slot    <= r_rd_slot;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_ADV;
                    end else if (r_rd_pend && last_slot) begin
                        r_hit     <= 1'b0;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_ADV;
                    end else begin
                        r_rd_pend <= rd_en;
                    end
                end
                S_ADV: begin
                    r_res_x   <= r_pen_x;
                    r_res_w   <= mul_p[11:0];
                    r_pen_x   <= r_pen_x + 16'(mul_p[11:0]);
                    r_rem     <= 8'd0;
                    r_quo     <= r_slot;
                    r_div_cnt <= DIV_CNT_W'(SLOT_W);
                    if (r_hit && (r_scale != 4'd0)) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem     <= div_ge ? 8'(div_trial - {1'b0, cols}) : div_trial[7:0];
                    r_quo     <= (r_quo << 1) | SLOT_W'(div_ge);
                    r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                    if (r_div_cnt == DIV_CNT_W'(1)) begin
                        r_state <= S_MUL_U;
                    end
                end
                S_MUL_U: begin
                    r_res_u <= mul_p[14:0];
                    r_state <= S_MUL_V;
                end
                S_MUL_V: begin
                    r_res_v <= mul_p[14:0];
                    r_state <= S_MUL_H;
                end
                S_MUL_H: begin
                    r_res_h <= mul_p[11:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
            r_sprite_x      <= r_res_x;
            r_sprite_y      <= r_pen_y;
            r_sprite_width  <= r_res_w;
            r_sprite_height <= r_res_h;
            r_source_u      <= r_res_u;
            r_source_v      <= r_res_v;
            r_draw_mode     <= eff_mode;
            r_tint          <= eff_color;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sprite_x      = r_sprite_x;
    assign o_sprite_y      = r_sprite_y;
    assign o_sprite_width  = r_sprite_width;
    assign o_sprite_height = r_sprite_height;
    assign o_source_u      = r_source_u;
    assign o_source_v      = r_source_v;
    assign o_draw_mode     = r_draw_mode;
    assign o_tint          = r_tint;

endmodule
`default_nettype wire
